// File: design/spherical_quad_subdivide_defines.svh
// Assertion macros shared by the subdivision block.
`ifndef SPHERICAL_QUAD_SUBDIVIDE_DEFINES_SVH
`define SPHERICAL_QUAD_SUBDIVIDE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define SQS_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define SQS_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sqs_pkg.sv
// Payload types shared by the subdivision pipeline and its output serializer.
`default_nettype none
package sqs_pkg;

  typedef struct packed {
    logic signed [31:0] c0_x;
    logic signed [31:0] c0_y;
    logic signed [31:0] c0_z;
    logic signed [31:0] c1_x;
    logic signed [31:0] c1_y;
    logic signed [31:0] c1_z;
    logic signed [31:0] c2_x;
    logic signed [31:0] c2_y;
    logic signed [31:0] c2_z;
    logic signed [31:0] c3_x;
    logic signed [31:0] c3_y;
    logic signed [31:0] c3_z;
  } sqs_in_t;

  typedef struct packed {
    logic [1:0]         child;
    logic [1:0]         child_corner;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               degenerate;
    logic               last;
  } sqs_out_t;

  // points 0..3 corners, 4..7 edge midpoints, 8 centroid
  typedef struct packed {
    logic [8:0][2:0][31:0] xyz;
    logic [8:0]            deg;
  } sqs_pts_t;

endpackage
`default_nettype wire

// File: design/spherical_quad_subdivide.sv
// Throughput is set by the output serializer, which sends the sixteen vertices of a
// quad back to back unless out_stall holds them, and by the root and divide stages,
// which retire 2 bits a cycle and take no new quad until all their steps are done.
// Stages are elastic: each holds its item until the next one is free, nothing is dropped.
// Reset (synchronous, rst_n low) clears all stage valid bits; data registers are not reset.
`default_nettype none
`include "spherical_quad_subdivide_defines.svh"
module spherical_quad_subdivide (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sqs_pkg::sqs_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output sqs_pkg::sqs_out_t     out_data
);

  localparam int NST     = 14;
  localparam int ST_LD   = 0;
  localparam int ST_SQ1  = 1;
  localparam int ST_SUM1 = 2;
  localparam int ST_RT1  = 3;
  localparam int ST_MUL1 = 4;
  localparam int ST_DIV1 = 5;
  localparam int ST_FIX1 = 6;
  localparam int ST_CAVG = 7;
  localparam int ST_SQ2  = 8;
  localparam int ST_SUM2 = 9;
  localparam int ST_RT2  = 10;
  localparam int ST_MUL2 = 11;
  localparam int ST_DIV2 = 12;
  localparam int ST_FIX2 = 13;
  localparam logic [NST-1:0] ITER = (14'd1 << ST_RT1) | (14'd1 << ST_DIV1) |
                                    (14'd1 << ST_RT2) | (14'd1 << ST_DIV2);
  localparam logic [4:0] STEPS = 5'd16;
  localparam logic [1:0] PAIR [5] = '{2'd3, 2'd2, 2'd0, 2'd1, 2'd3};

  // lanes 0..3 edge midpoints, lane 4 corner 0 for the radius; lane 0 reused for centroid
  typedef struct packed {
    logic [3:0][2:0][31:0] corner;
    logic [3:0][2:0][31:0] mid;
    logic [3:0]            mid_deg;
    logic [2:0][31:0]      cen;
    logic                  cen_deg;
    logic [4:0][2:0][31:0] vec;
    logic [4:0][2:0][63:0] sq;
    logic [4:0][63:0]      sh;
    logic [4:0][34:0]      rem;
    logic [4:0][31:0]      root;
    logic [31:0]           radius;
    logic [3:0][31:0]      den;
    logic [3:0][2:0][32:0] drem;
    logic [3:0][2:0][31:0] dsh;
    logic [3:0][2:0][31:0] quo;
  } sqs_work_t;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [31:0] fhalf(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction

  function automatic logic [31:0] sat(input logic [31:0] v, input logic [31:0] q,
                                      input logic zero);
    logic [31:0] r;
    if (zero) begin
      r = 32'd0;
    end else if (v[31]) begin
      r = (q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
    end else begin
      r = (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
    end
    return r;
  endfunction

  function automatic sqs_work_t lane_sq(input sqs_work_t w, input int l);
    sqs_work_t   o;
    logic [31:0] m;
    o = w;
    for (int j = 0; j < 3; j++) begin
      m = mag32(w.vec[l][j]);
      o.sq[l][j] = 64'(m) * 64'(m);
    end
    return o;
  endfunction

  function automatic sqs_work_t lane_sum(input sqs_work_t w, input int l);
    sqs_work_t o;
    o = w;
    o.sh[l]   = w.sq[l][0] + w.sq[l][1] + w.sq[l][2];
    o.rem[l]  = 35'd0;
    o.root[l] = 32'd0;
    return o;
  endfunction

  // two bit-pairs of the digit-by-digit square root
  function automatic sqs_work_t lane_rt(input sqs_work_t w, input int l);
    sqs_work_t   o;
    logic [34:0] r;
    logic [34:0] t;
    logic [31:0] q;
    o = w;
    r = w.rem[l];
    q = w.root[l];
    for (int i = 0; i < 2; i++) begin
      r = {r[32:0], w.sh[l][63-2*i -: 2]};
      t = {1'b0, q, 2'b01};
      if (r >= t) begin
        r = r - t;
        q = {q[30:0], 1'b1};
      end else begin
        q = {q[30:0], 1'b0};
      end
    end
    o.rem[l]  = r;
    o.root[l] = q;
    o.sh[l]   = {w.sh[l][59:0], 4'd0};
    return o;
  endfunction

  // quotient fits 32 bits since each coordinate is at most the vector length
  function automatic sqs_work_t lane_mul(input sqs_work_t w, input int l,
                                         input logic [31:0] rad);
    sqs_work_t   o;
    logic [63:0] p;
    o = w;
    o.den[l] = w.root[l];
    for (int j = 0; j < 3; j++) begin
      p = 64'(mag32(w.vec[l][j])) * 64'(rad);
      o.drem[l][j] = {1'b0, p[63:32]};
      o.dsh[l][j]  = p[31:0];
      o.quo[l][j]  = 32'd0;
    end
    return o;
  endfunction

  function automatic sqs_work_t lane_div(input sqs_work_t w, input int l);
    sqs_work_t   o;
    logic [32:0] r;
    logic [31:0] q;
    o = w;
    for (int j = 0; j < 3; j++) begin
      r = w.drem[l][j];
      q = w.quo[l][j];
      for (int i = 0; i < 2; i++) begin
        r = {r[31:0], w.dsh[l][j][31-i]};
        if (r >= {1'b0, w.den[l]}) begin
          r = r - {1'b0, w.den[l]};
          q = {q[30:0], 1'b1};
        end else begin
          q = {q[30:0], 1'b0};
        end
      end
      o.drem[l][j] = r;
      o.quo[l][j]  = q;
      o.dsh[l][j]  = {w.dsh[l][j][29:0], 2'b00};
    end
    return o;
  endfunction

  function automatic sqs_work_t stage_fn(input int k, input sqs_work_t w);
    sqs_work_t o;
    o = w;
    case (k)
      ST_LD: begin
        for (int l = 0; l < 4; l++) begin
          for (int j = 0; j < 3; j++) begin
            o.vec[l][j] = fhalf(w.corner[PAIR[l]][j], w.corner[PAIR[l+1]][j]);
          end
        end
        o.vec[4] = w.corner[0];
      end
      ST_SQ1:  for (int l = 0; l < 5; l++) o = lane_sq(o, l);
      ST_SUM1: for (int l = 0; l < 5; l++) o = lane_sum(o, l);
      ST_RT1:  for (int l = 0; l < 5; l++) o = lane_rt(o, l);
      ST_MUL1: begin
        o.radius = w.root[4];
        for (int l = 0; l < 4; l++) o = lane_mul(o, l, w.root[4]);
      end
      ST_DIV1: for (int l = 0; l < 4; l++) o = lane_div(o, l);
      ST_FIX1: begin
        for (int l = 0; l < 4; l++) begin
          o.mid_deg[l] = (w.den[l] == 32'd0);
          for (int j = 0; j < 3; j++) begin
            o.mid[l][j] = sat(w.vec[l][j], w.quo[l][j], w.den[l] == 32'd0);
          end
        end
      end
      ST_CAVG: begin
        for (int j = 0; j < 3; j++) o.vec[0][j] = fhalf(w.mid[0][j], w.mid[2][j]);
      end
      ST_SQ2:  o = lane_sq(o, 0);
      ST_SUM2: o = lane_sum(o, 0);
      ST_RT2:  o = lane_rt(o, 0);
      ST_MUL2: o = lane_mul(o, 0, w.radius);
      ST_DIV2: o = lane_div(o, 0);
      ST_FIX2: begin
        o.cen_deg = (w.den[0] == 32'd0);
        for (int j = 0; j < 3; j++) o.cen[j] = sat(w.vec[0][j], w.quo[0][j], w.den[0] == 32'd0);
      end
      default: ;
    endcase
    return o;
  endfunction

  sqs_work_t         work_r   [NST];
  sqs_work_t         work_nxt [NST];
  logic [4:0]        cnt_r    [NST];
  logic [4:0]        cnt_nxt  [NST];
  logic [NST-1:0]    v_r, v_nxt, done, free, move, step;
  sqs_work_t         w_in;
  sqs_work_t         src;
  logic              emit_free;
  sqs_pkg::sqs_pts_t pts;

  always_comb begin
    w_in = '0;
    w_in.corner[0][0] = in_data.c0_x;
    w_in.corner[0][1] = in_data.c0_y;
    w_in.corner[0][2] = in_data.c0_z;
    w_in.corner[1][0] = in_data.c1_x;
    w_in.corner[1][1] = in_data.c1_y;
    w_in.corner[1][2] = in_data.c1_z;
    w_in.corner[2][0] = in_data.c2_x;
    w_in.corner[2][1] = in_data.c2_y;
    w_in.corner[2][2] = in_data.c2_z;
    w_in.corner[3][0] = in_data.c3_x;
    w_in.corner[3][1] = in_data.c3_y;
    w_in.corner[3][2] = in_data.c3_z;
  end

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      done[k] = v_r[k] && (!ITER[k] || cnt_r[k] == STEPS);
      step[k] = v_r[k] && ITER[k] && !done[k];
    end
    // a stage is free when it is empty or when its item leaves this cycle
    for (int k = NST - 1; k >= 0; k--) begin
      free[k] = !v_r[k] || (done[k] && ((k == NST - 1) ? emit_free : free[k+1]));
    end
    for (int k = 0; k < NST; k++) begin
      move[k] = ((k == 0) ? in_valid : done[k-1]) && free[k];
    end
    for (int k = 0; k < NST; k++) begin
      v_nxt[k]    = move[k] || (v_r[k] && !(done[k] &&
                    ((k == NST - 1) ? emit_free : free[k+1])));
      cnt_nxt[k]  = move[k] ? 5'd1 : (step[k] ? cnt_r[k] + 5'd1 : cnt_r[k]);
      src         = move[k] ? ((k == 0) ? w_in : work_r[k-1]) : work_r[k];
      work_nxt[k] = (move[k] || step[k]) ? stage_fn(k, src) : work_r[k];
    end
  end

  assign in_stall = !free[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      work_r[k] <= work_nxt[k];
      cnt_r[k]  <= cnt_nxt[k];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pts.xyz[i]   = work_r[NST-1].corner[i];
      pts.xyz[i+4] = work_r[NST-1].mid[i];
      pts.deg[i]   = 1'b0;
      pts.deg[i+4] = work_r[NST-1].mid_deg[i];
    end
    pts.xyz[8] = work_r[NST-1].cen;
    pts.deg[8] = work_r[NST-1].cen_deg;
  end

  sqs_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (done[NST-1]),
    .ld_pts    (pts),
    .ld_free   (emit_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `SQS_AST_NXT(a_in_lands, in_valid && !in_stall, v_r[ST_LD], "input transfer not captured")
  `SQS_AST_IMP(a_rt_count, v_r[ST_RT1], cnt_r[ST_RT1] >= 5'd1 && cnt_r[ST_RT1] <= STEPS, "root step count out of range")
  `SQS_AST_NXT(a_tail_holds, v_r[NST-1] && !emit_free, v_r[NST-1], "finished quad lost while serializer busy")

endmodule
`default_nettype wire

// File: design/sqs_emit.sv
// Output serializer: walks the sixteen child-quad corners of one finished quad.
`default_nettype none
`include "spherical_quad_subdivide_defines.svh"
module sqs_emit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             ld_valid,
  input  wire sqs_pkg::sqs_pts_t ld_pts,
  output logic                  ld_free,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output sqs_pkg::sqs_out_t     out_data
);

  localparam logic [3:0] LASTIDX = 4'd15;
  localparam logic [3:0] LAYOUT [16] = '{
    4'd0, 4'd6, 4'd5, 4'd8,
    4'd6, 4'd1, 4'd8, 4'd7,
    4'd5, 4'd8, 4'd2, 4'd4,
    4'd8, 4'd7, 4'd4, 4'd3
  };

  logic              v_r, v_nxt;
  logic [3:0]        idx_r, idx_nxt;
  sqs_pkg::sqs_pts_t pts_r, pts_nxt;
  logic [3:0]        pt;

  assign ld_free = !v_r || (idx_r == LASTIDX && !out_stall);

  always_comb begin
    v_nxt   = v_r;
    idx_nxt = idx_r;
    pts_nxt = pts_r;
    if (ld_valid && ld_free) begin
      v_nxt   = 1'b1;
      idx_nxt = 4'd0;
      pts_nxt = ld_pts;
    end else if (v_r && !out_stall) begin
      if (idx_r == LASTIDX) begin
        v_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pts_r <= pts_nxt;
  end

  always_comb begin
    pt                    = LAYOUT[idx_r];
    out_data.child        = idx_r[3:2];
    out_data.child_corner = idx_r[1:0];
    out_data.out_x        = pts_r.xyz[pt][0];
    out_data.out_y        = pts_r.xyz[pt][1];
    out_data.out_z        = pts_r.xyz[pt][2];
    out_data.degenerate   = pts_r.deg[pt];
    out_data.last         = (idx_r == LASTIDX);
  end

  assign out_valid = v_r;

  `SQS_AST_NXT(a_load_starts, ld_valid && ld_free, v_r && idx_r == 4'd0, "load did not restart walk")
  `SQS_AST_NXT(a_walk_steps, v_r && !out_stall && idx_r != LASTIDX, v_r && idx_r == $past(idx_r) + 4'd1, "vertex skipped or repeated")
  `SQS_AST_NXT(a_walk_ends, v_r && !out_stall && idx_r == LASTIDX && !ld_valid, !v_r, "walk ran past last vertex")

endmodule
`default_nettype wire
